// ===== rtl/wfs_pkg.sv =====
`default_nettype none
package wfs_pkg;

	localparam int MAX_WAYPOINTS = 64;
	localparam int AW            = $clog2(MAX_WAYPOINTS);
	localparam int LEN_W         = 7;
	localparam int REACH_UNITS   = 160;
	localparam int REACH_SQ      = REACH_UNITS * REACH_UNITS;
	localparam int QW            = 20;
	localparam int SQRT_STEPS    = 32;
	localparam int CNT_W         = 6;
	localparam int IN_W          = 120;
	localparam int OUT_W         = 112;

	typedef enum logic [1:0] {
		KIND_LOAD  = 2'd0,
		KIND_START = 2'd1,
		KIND_TICK  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic {
		REG_SPEED     = 1'b0,
		REG_ROUTE_LEN = 1'b1
	} reg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_READ, S_DIFF, S_SHIFT, S_SQ, S_ACC, S_SQI, S_SQRT,
		S_STEP, S_MUL, S_DIVI, S_DIV, S_UPD, S_DONE
	} state_t;

	typedef struct packed {
		logic       accept;
		logic       diff;
		logic       shift;
		logic       sq;
		logic       acc;
		logic       sqrt_init;
		logic       sqrt_step;
		logic       step;
		logic       mul;
		logic       div_init;
		logic       div_step;
		logic       upd;
		logic       res_load;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic tick_err;
		logic zero;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// ===== rtl/waypoint_follow_step.sv =====
`default_nettype none
// Constant-speed 3D waypoint follower. One result transaction per input
// transaction. Load, start and no-op items go straight to the result stage.
// A tick goes through a 32x32 multiplier, a 32-step iterative square root
// and a 20-step restoring divider used once per axis. Ticks with an empty
// route or a target outside the route go straight to the result stage; a
// tick at zero distance skips the multiply and divide passes. A new input is
// taken while a finished result still waits on the output side. There is no
// clearing pass after reset, so route slots read before being loaded give
// undefined positions.
module waypoint_follow_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_axis_tvalid,
	output logic                               s_axis_tready,
	// wp_index[5:0], east[37:6], north[69:38], up[101:70], dt[117:102]
	input  wire logic [wfs_pkg::IN_W-1:0]      s_axis_tdata,
	// kind[1:0]
	input  wire logic [1:0]                    s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  wire logic                          m_axis_tready,
	// pos_east[31:0], pos_north[63:32], pos_up[95:64], target_index[101:96],
	// arrived[102], status[104:103]
	output logic [wfs_pkg::OUT_W-1:0]          m_axis_tdata,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [15:0]                   cfg_data
);
	import wfs_pkg::*;

	cmd_t               cmd;
	dp_sts_t            sts;
	logic signed [31:0] pos_east, pos_north, pos_up;
	logic [5:0]         target_index;
	logic               arrived;
	logic [1:0]         status;

	wfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_kind  (s_axis_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	wfs_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (s_axis_tuser),
		.wp_index     (s_axis_tdata[5:0]),
		.east         (s_axis_tdata[37:6]),
		.north        (s_axis_tdata[69:38]),
		.up           (s_axis_tdata[101:70]),
		.dt           (s_axis_tdata[117:102]),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.pos_east     (pos_east),
		.pos_north    (pos_north),
		.pos_up       (pos_up),
		.target_index (target_index),
		.arrived      (arrived),
		.status       (status)
	);

	assign m_axis_tdata = {7'd0, status, arrived, target_index, pos_up, pos_north, pos_east};

endmodule
`default_nettype wire

// ===== rtl/wfs_dp.sv =====
`default_nettype none
module wfs_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wfs_pkg::cmd_t        cmd,
	output wfs_pkg::dp_sts_t     sts,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic [1:0]           kind,
	input  logic [5:0]           wp_index,
	input  logic signed [31:0]   east,
	input  logic signed [31:0]   north,
	input  logic signed [31:0]   up,
	input  logic [15:0]          dt,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [31:0]   pos_east,
	output logic signed [31:0]   pos_north,
	output logic signed [31:0]   pos_up,
	output logic [5:0]           target_index,
	output logic                 arrived,
	output logic [1:0]           status
);
	import wfs_pkg::*;

	logic [15:0]        speed_q;
	logic [LEN_W-1:0]   route_len_q;
	logic signed [31:0] here_q [3];
	logic [5:0]         tgt_q;
	logic               out_valid_q;

	kind_t              kind_q;
	logic [15:0]        dt_q;
	status_t            stat_q;
	logic [95:0]        mem [MAX_WAYPOINTS];
	logic [95:0]        rd_q;
	logic signed [32:0] d_q [3];
	logic signed [31:0] re_q [3];
	logic [31:0]        mag_q [3];
	logic               small_q;
	logic [63:0]        prod_q;
	logic [63:0]        sum_q;
	logic               reached_q;
	logic               zero_q;
	logic [63:0]        v_q;
	logic [34:0]        srem_q;
	logic [31:0]        root_q;
	logic [31:0]        step_q;
	logic [64:0]        drem_q;
	logic [64:0]        dsh_q;
	logic [QW-1:0]      quo_q;
	logic signed [31:0] opos_q [3];
	logic [5:0]         otgt_q;
	logic               oarr_q;
	status_t            ostat_q;

	logic [LEN_W-1:0]   len;
	status_t            tick_stat;
	logic signed [31:0] in_pt [3];
	logic signed [31:0] rd_pt [3];
	logic [32:0]        ab [3];
	logic               big;
	logic signed [32:0] shv [3];
	logic signed [31:0] rev [3];
	logic [34:0]        srem_n;
	logic [34:0]        strial;
	logic [31:0]        root_c;
	logic [45:0]        den;
	logic signed [33:0] hs;
	logic signed [33:0] nv;
	logic signed [31:0] satv;
	logic               adv;
	logic               last;

	assign in_pt[0] = east;
	assign in_pt[1] = north;
	assign in_pt[2] = up;
	assign rd_pt[0] = rd_q[31:0];
	assign rd_pt[1] = rd_q[63:32];
	assign rd_pt[2] = rd_q[95:64];

	always_comb begin
		len = (int'(route_len_q) > MAX_WAYPOINTS) ? LEN_W'(MAX_WAYPOINTS) : route_len_q;
		if (len == '0) begin
			tick_stat = STAT_EMPTY;
		end else if (LEN_W'(tgt_q) >= len) begin
			tick_stat = STAT_RANGE;
		end else begin
			tick_stat = STAT_OK;
		end
		for (int i = 0; i < 3; i++) begin
			ab[i] = d_q[i][32] ? 33'(-d_q[i]) : 33'(d_q[i]);
		end
		big = |{ab[0][32:31], ab[1][32:31], ab[2][32:31]};
		for (int i = 0; i < 3; i++) begin
			shv[i] = big ? (d_q[i] >>> 1) : d_q[i];
			rev[i] = shv[i][31:0];
		end
		srem_n = {srem_q[32:0], v_q[63:62]};
		strial = {1'b0, root_q, 2'b01};
		root_c = (root_q == '0) ? 32'd1 : root_q;
		den    = {root_c, 14'd0};
		hs     = {{2{here_q[cmd.axis][31]}}, here_q[cmd.axis]};
		nv     = re_q[cmd.axis][31] ? hs - 34'(quo_q) : hs + 34'(quo_q);
		if (nv[33:31] == 3'b000 || nv[33:31] == 3'b111) begin
			satv = nv[31:0];
		end else begin
			satv = nv[33] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
		end
		adv  = (kind_q == KIND_TICK) && (stat_q == STAT_OK) && reached_q;
		last = (LEN_W'(tgt_q) == len - LEN_W'(1));
	end

	assign sts.tick_err = (tick_stat != STAT_OK);
	assign sts.zero     = zero_q;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= '0;
			route_len_q <= '0;
			for (int i = 0; i < 3; i++) here_q[i] <= '0;
			tgt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_t'(cfg_index))
					REG_SPEED:     speed_q <= cfg_data;
					REG_ROUTE_LEN: route_len_q <= cfg_data[LEN_W-1:0];
					default:       ;
				endcase
			end
			if (cmd.accept && kind_t'(kind) == KIND_START) begin
				for (int i = 0; i < 3; i++) here_q[i] <= in_pt[i];
				tgt_q <= wp_index;
			end
			if (cmd.upd) begin
				here_q[cmd.axis] <= satv;
			end
			if (cmd.res_load && adv && !last) begin
				tgt_q <= tgt_q + 6'd1;
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && kind_t'(kind) == KIND_LOAD && int'(wp_index) < MAX_WAYPOINTS) begin
			mem[AW'(wp_index)] <= {up, north, east};
		end
		rd_q <= mem[AW'(tgt_q)];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			kind_q <= kind_t'(kind);
			dt_q   <= dt;
			stat_q <= (kind_t'(kind) == KIND_TICK) ? tick_stat : STAT_OK;
		end
		if (cmd.diff) begin
			for (int i = 0; i < 3; i++) begin
				d_q[i] <= {rd_pt[i][31], rd_pt[i]} - {here_q[i][31], here_q[i]};
			end
		end
		if (cmd.shift) begin
			for (int i = 0; i < 3; i++) begin
				re_q[i]  <= rev[i];
				mag_q[i] <= rev[i][31] ? 32'(-rev[i]) : 32'(rev[i]);
			end
			small_q <= (ab[0] < 33'(REACH_UNITS)) && (ab[1] < 33'(REACH_UNITS))
				&& (ab[2] < 33'(REACH_UNITS));
		end
		if (cmd.sq) begin
			prod_q <= 64'(mag_q[cmd.axis]) * 64'(mag_q[cmd.axis]);
		end
		if (cmd.acc) begin
			sum_q <= ((cmd.axis == 2'd0) ? 64'd0 : sum_q) + prod_q;
		end
		if (cmd.sqrt_init) begin
			v_q       <= sum_q;
			srem_q    <= '0;
			root_q    <= '0;
			reached_q <= small_q && (sum_q < 64'(REACH_SQ));
			zero_q    <= (sum_q == '0);
		end
		if (cmd.sqrt_step) begin
			v_q <= {v_q[61:0], 2'b00};
			if (srem_n >= strial) begin
				srem_q <= srem_n - strial;
				root_q <= {root_q[30:0], 1'b1};
			end else begin
				srem_q <= srem_n;
				root_q <= {root_q[30:0], 1'b0};
			end
		end
		if (cmd.step) begin
			step_q <= 32'(speed_q) * 32'(dt_q);
		end
		if (cmd.mul) begin
			prod_q <= 64'(mag_q[cmd.axis]) * 64'(step_q);
		end
		if (cmd.div_init) begin
			drem_q <= 65'(prod_q) + 65'(den >> 1);
			dsh_q  <= 65'(den) << (QW - 1);
			quo_q  <= '0;
		end
		if (cmd.div_step) begin
			dsh_q <= dsh_q >> 1;
			if (drem_q >= dsh_q) begin
				drem_q <= drem_q - dsh_q;
				quo_q  <= {quo_q[QW-2:0], 1'b1};
			end else begin
				quo_q  <= {quo_q[QW-2:0], 1'b0};
			end
		end
		if (cmd.res_load) begin
			for (int i = 0; i < 3; i++) opos_q[i] <= here_q[i];
			otgt_q  <= (adv && !last) ? tgt_q + 6'd1 : tgt_q;
			oarr_q  <= adv && last;
			ostat_q <= stat_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_east     = opos_q[0];
	assign pos_north    = opos_q[1];
	assign pos_up       = opos_q[2];
	assign target_index = otgt_q;
	assign arrived      = oarr_q;
	assign status       = ostat_q;

endmodule
`default_nettype wire

// ===== rtl/wfs_ctrl.sv =====
`default_nettype none
module wfs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          in_kind,
	input  wfs_pkg::dp_sts_t    sts,
	output wfs_pkg::cmd_t       cmd
);
	import wfs_pkg::*;

	state_t           state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [1:0]       axis_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (kind_t'(in_kind) == KIND_TICK && !sts.tick_err) begin
						state_n = S_READ;
					end else begin
						state_n = S_DONE;
					end
				end
			end
			S_READ:  state_n = S_DIFF;
			S_DIFF:  state_n = S_SHIFT;
			S_SHIFT: state_n = S_SQ;
			S_SQ:    state_n = S_ACC;
			S_ACC:   state_n = (axis_q == 2'd2) ? S_SQI : S_SQ;
			S_SQI:   state_n = S_SQRT;
			S_SQRT:  state_n = (cnt_q == CNT_W'(SQRT_STEPS - 1)) ? S_STEP : S_SQRT;
			S_STEP:  state_n = sts.zero ? S_DONE : S_MUL;
			S_MUL:   state_n = S_DIVI;
			S_DIVI:  state_n = S_DIV;
			S_DIV:   state_n = (cnt_q == CNT_W'(QW - 1)) ? S_UPD : S_DIV;
			S_UPD:   state_n = (axis_q == 2'd2) ? S_DONE : S_MUL;
			S_DONE:  state_n = sts.out_free ? S_IDLE : S_DONE;
			default: state_n = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.axis      = axis_q;
		cmd.accept    = (state_q == S_IDLE) && in_valid;
		cmd.diff      = (state_q == S_DIFF);
		cmd.shift     = (state_q == S_SHIFT);
		cmd.sq        = (state_q == S_SQ);
		cmd.acc       = (state_q == S_ACC);
		cmd.sqrt_init = (state_q == S_SQI);
		cmd.sqrt_step = (state_q == S_SQRT);
		cmd.step      = (state_q == S_STEP);
		cmd.mul       = (state_q == S_MUL);
		cmd.div_init  = (state_q == S_DIVI);
		cmd.div_step  = (state_q == S_DIV);
		cmd.upd       = (state_q == S_UPD);
		cmd.res_load  = (state_q == S_DONE) && sts.out_free;
		in_ready      = (state_q == S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			axis_q  <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == S_SQRT || state_q == S_DIV) begin
				cnt_q <= (state_n == state_q) ? cnt_q + CNT_W'(1) : '0;
			end else begin
				cnt_q <= '0;
			end
			if (state_q == S_IDLE || state_q == S_SQI) begin
				axis_q <= '0;
			end else if (state_q == S_ACC || state_q == S_UPD) begin
				axis_q <= axis_q + 2'd1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> sts.out_free)
		else $error("result written while output register occupied");
	a_sqrt_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SQRT |-> cnt_q < CNT_W'(SQRT_STEPS))
		else $error("root iteration overrun");
	a_last_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && axis_q == 2'd2) |=> state_q == S_DONE)
		else $error("axis loop did not finish");
	a_load_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && kind_t'(in_kind) == KIND_LOAD) |=> state_q == S_DONE)
		else $error("load transaction did not complete directly");
`endif

endmodule
`default_nettype wire

// ===== dv/waypoint_follow_step_test.sv =====
`timescale 1ns / 100ps
module waypoint_follow_step_test;
	import wfs_pkg::*;

	typedef struct {
		logic signed [31:0] pos [3];
		logic [5:0]         tgt;
		logic               arr;
		status_t            st;
	} nav_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_W-1:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	waypoint_follow_step dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// navigator state as the block should hold it
	logic signed [31:0] route [3][MAX_WAYPOINTS];
	bit                 loaded [MAX_WAYPOINTS];
	logic signed [31:0] here [3];
	logic [5:0]         next_tgt;
	logic [15:0]        speed_q;
	logic [6:0]         route_len_q;
	bit                 last_arrived;

	nav_result_t expected_q [$];
	int errors = 0;
	int n_items = 0;
	int n_results = 0;
	int n_arrivals = 0;
	int n_status_err = 0;
	bit quiet = 0;
	int rx_hold = 0;
	int rx_wait = 0;

	function automatic longint unsigned mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	function automatic int eff_len();
		return route_len_q > MAX_WAYPOINTS ? MAX_WAYPOINTS : route_len_q;
	endfunction

	function automatic nav_result_t navigate(kind_t k, logic [5:0] idx,
			logic signed [31:0] c [3], logic [15:0] dt);
		nav_result_t r;
		longint d [3];
		longint rs [3];
		longint unsigned a [3];
		longint unsigned mx, sumsq, span, stp, den, m;
		int sh, len, t;
		bit reached;
		r.arr = 0;
		r.st = STAT_OK;
		len = eff_len();
		case (k)
		KIND_LOAD: begin
			for (int i = 0; i < 3; i++)
				route[i][idx] = c[i];
			loaded[idx] = 1;
		end
		KIND_START: begin
			here = c;
			next_tgt = idx;
		end
		KIND_TICK: begin
			if (len == 0) begin
				r.st = STAT_EMPTY;
			end else if (next_tgt >= len) begin
				r.st = STAT_RANGE;
			end else begin
				t = next_tgt;
				mx = 0;
				sumsq = 0;
				for (int i = 0; i < 3; i++) begin
					d[i] = longint'(route[i][t]) - longint'(here[i]);
					a[i] = mag(d[i]);
					if (a[i] > mx)
						mx = a[i];
					sumsq += a[i] * a[i];
				end
				reached = a[0] < REACH_UNITS && a[1] < REACH_UNITS && a[2] < REACH_UNITS
					&& sumsq < REACH_SQ;
				sh = 0;
				while ((mx >> sh) > 64'h7FFFFFFF)
					sh++;
				if (mx != 0) begin
					sumsq = 0;
					for (int i = 0; i < 3; i++) begin
						rs[i] = d[i] >>> sh;
						sumsq += mag(rs[i]) * mag(rs[i]);
					end
					span = floor_sqrt(sumsq);
					stp = longint'(speed_q) * longint'(dt);
					if (span == 0)
						span = 1;
					den = span << 14;
					for (int i = 0; i < 3; i++) begin
						m = (mag(rs[i]) * stp + (den >> 1)) / den;
						here[i] = clamp32(rs[i] < 0 ? longint'(here[i]) - longint'(m)
							: longint'(here[i]) + longint'(m));
					end
				end
				if (reached) begin
					if (t == len - 1)
						r.arr = 1;
					else
						next_tgt = t + 1;
				end
			end
		end
		default: ;
		endcase
		r.pos = here;
		r.tgt = next_tgt;
		return r;
	endfunction

	task automatic send_raw(kind_t k, logic [5:0] idx, logic signed [31:0] c [3],
			logic [15:0] dt);
		int gap;
		nav_result_t r;
		gap = quiet ? 0 : $urandom_range(0, 5);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = {2'b00, dt, c[2], c[1], c[0], idx};
		s_axis_tuser = k;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		r = navigate(k, idx, c, dt);
		last_arrived = r.arr;
		expected_q.push_back(r);
		n_items++;
	endtask

	// ticks never read a slot that was not loaded since reset
	task automatic send_item(kind_t k, logic [5:0] idx, logic signed [31:0] c [3],
			logic [15:0] dt);
		logic signed [31:0] w [3];
		if (k == KIND_TICK && next_tgt < eff_len() && !loaded[next_tgt]) begin
			for (int i = 0; i < 3; i++)
				w[i] = here[i] + $signed($urandom_range(0, 4000)) - 2000;
			send_raw(KIND_LOAD, next_tgt, w, $urandom);
		end
		send_raw(k, idx, c, dt);
	endtask

	task automatic tick(logic [15:0] dt);
		logic signed [31:0] z [3];
		z = '{0, 0, 0};
		send_item(KIND_TICK, $urandom, z, dt);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic write_reg(reg_t r, logic [15:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = r;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (r == REG_SPEED)
			speed_q = v;
		else
			route_len_q = v[6:0];
	endtask

	// receiver: per-transaction stall plus an optional long hold-off
	initial forever begin
		@(negedge clk);
		if (rx_hold > 0) begin
			m_axis_tready = 1'b0;
			rx_hold--;
		end else if (rx_wait > 0) begin
			m_axis_tready = 1'b0;
			rx_wait--;
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		nav_result_t e;
		logic signed [31:0] p [3];
		if (m_axis_tvalid && m_axis_tready) begin
			rx_wait = quiet ? 0 : $urandom_range(0, 5);
			n_results++;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result transaction %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = expected_q.pop_front();
				p[0] = m_axis_tdata[31:0];
				p[1] = m_axis_tdata[63:32];
				p[2] = m_axis_tdata[95:64];
				for (int i = 0; i < 3; i++)
					if (p[i] !== e.pos[i]) begin
						$display("%0t: pos axis %0d expected %0d actual %0d",
							$time, i, e.pos[i], p[i]);
						errors++;
					end
				if (m_axis_tdata[101:96] !== e.tgt) begin
					$display("%0t: target_index expected %0d actual %0d",
						$time, e.tgt, m_axis_tdata[101:96]);
					errors++;
				end
				if (m_axis_tdata[102] !== e.arr) begin
					$display("%0t: arrived expected %0d actual %0d",
						$time, e.arr, m_axis_tdata[102]);
					errors++;
				end
				if (m_axis_tdata[104:103] !== e.st) begin
					$display("%0t: status expected %0d actual %0d",
						$time, e.st, m_axis_tdata[104:103]);
					errors++;
				end
				if (e.arr)
					n_arrivals++;
				if (e.st != STAT_OK)
					n_status_err++;
			end
		end
	end

	task automatic test_empty_route();
		logic signed [31:0] c [3];
		c = '{100, -100, 7};
		tick(1024);
		send_item(KIND_NOP, 6'h3F, c, 16'hFFFF);
		send_item(KIND_START, 0, c, 0);
		tick(16'hFFFF);
		wait_idle();
	endtask

	task automatic test_index_range();
		logic signed [31:0] c [3];
		write_reg(REG_SPEED, 16'hFFFF);
		write_reg(REG_ROUTE_LEN, 2);
		c = '{0, 0, 0};
		send_item(KIND_LOAD, 0, c, 0);
		send_item(KIND_LOAD, 1, c, 0);
		send_item(KIND_START, 5, c, 0);
		tick(1000);
		send_item(KIND_START, 2, c, 0);
		tick(1000);
		wait_idle();
	endtask

	task automatic test_zero_distance();
		logic signed [31:0] c [3];
		write_reg(REG_ROUTE_LEN, 1);
		c = '{-5000, 123456, -77};
		send_item(KIND_LOAD, 0, c, 0);
		send_item(KIND_START, 0, c, 0);
		tick(2048);
		tick(0);
		wait_idle();
	endtask

	task automatic test_saturation();
		logic signed [31:0] c [3];
		logic signed [31:0] s [3];
		write_reg(REG_SPEED, 16'hFFFF);
		write_reg(REG_ROUTE_LEN, 127);
		c = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000};
		s = '{32'sh7FFFFFA0, 32'sh7FFFFFF0, 32'sh80000040};
		send_item(KIND_LOAD, 63, c, 0);
		send_item(KIND_START, 63, s, 0);
		tick(16'hFFFF);
		tick(16'hFFFF);
		// full-scale difference needs the pre-shift
		c = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000};
		s = '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF};
		send_item(KIND_LOAD, 0, c, 0);
		send_item(KIND_START, 0, s, 0);
		tick(16'hFFFF);
		wait_idle();
		write_reg(REG_SPEED, 0);
		tick(16'hFFFF);
		wait_idle();
	endtask

	task automatic run_route(int len, bit wide);
		logic signed [31:0] c [3];
		int ticks;
		logic [15:0] dt;
		write_reg(REG_SPEED, wide ? $urandom : $urandom_range(1500, 3500));
		write_reg(REG_ROUTE_LEN, len);
		for (int i = 0; i < 3; i++)
			c[i] = $signed($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000;
		for (int w = 0; w < eff_len() && w < 10; w++) begin
			for (int i = 0; i < 3; i++)
				c[i] += $signed($urandom_range(0, 1200)) - 600;
			send_item(KIND_LOAD, w, c, $urandom);
		end
		for (int i = 0; i < 3; i++)
			c[i] = route[i][0] + $signed($urandom_range(0, 1000)) - 500;
		send_item(KIND_START, ($urandom_range(0, 9) == 0) ? $urandom : 0, c, $urandom);
		ticks = 0;
		last_arrived = 0;
		while (!last_arrived && ticks < 40) begin
			dt = wide ? $urandom : $urandom_range(1024, 1536);
			if ($urandom_range(0, 15) == 0) begin
				for (int i = 0; i < 3; i++)
					c[i] = $urandom;
				send_item(kind_t'($urandom_range(0, 3) == 0 ? KIND_NOP : KIND_LOAD),
					$urandom_range(10, 63), c, $urandom);
			end
			tick(dt);
			ticks++;
		end
		wait_idle();
	endtask

	task automatic test_random_noise();
		logic signed [31:0] c [3];
		for (int j = 0; j < 12; j++) begin
			for (int i = 0; i < 3; i++)
				c[i] = $urandom;
			send_item(kind_t'($urandom_range(0, 3)), $urandom, c, $urandom);
		end
		wait_idle();
	endtask

	task automatic test_backpressure();
		quiet = 1;
		rx_hold = 400;
		for (int j = 0; j < 20; j++)
			tick($urandom_range(512, 2048));
		wait_idle();
		quiet = 0;
	endtask

	task automatic test_random();
		int len, pick;
		while (n_items < 700) begin
			quiet = ($urandom_range(0, 7) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 2) begin
				test_random_noise();
			end else begin
				len = (pick == 2) ? 0 : (pick == 3) ? 64 : (pick == 4) ? 127
					: $urandom_range(1, 8);
				run_route(len, pick == 5);
			end
		end
		quiet = 0;
	endtask

	initial begin
		for (int i = 0; i < MAX_WAYPOINTS; i++)
			loaded[i] = 0;
		here = '{0, 0, 0};
		next_tgt = 0;
		speed_q = 0;
		route_len_q = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_empty_route();
		test_index_range();
		test_zero_distance();
		test_saturation();
		run_route(3, 0);
		test_backpressure();
		test_random();
		wait_idle();
		$display("Covered %0d input transactions, %0d results, %0d arrivals,",
			n_items, n_results, n_arrivals);
		$display("%0d error-status ticks, saturation, back-pressure and config extremes.",
			n_status_err);
		if (errors == 0 && expected_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout at %0t", $time);
		$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== waypoint_follow_step.f =====
rtl/wfs_pkg.sv
rtl/wfs_dp.sv
rtl/wfs_ctrl.sv
rtl/waypoint_follow_step.sv
dv/waypoint_follow_step_test.sv
